// File: rtl/core/mbrot_pkg.sv
package mbrot_pkg;

  // fixed-point format of the complex plane
  localparam int FRAC_BITS = 40;
  localparam int CFG_W     = 48;
  localparam int LIM_W     = 13;
  localparam int PIX_W     = 10;
  localparam int IDX_W     = 3;

  // c = origin + pixel * step always fits 59 signed bits
  localparam int CW  = 59;
  // z after one update stays below 2^59 in magnitude
  localparam int ZW  = 60;
  // a non-escaped |z| component is below 10.0, so 44 bits
  localparam int MW  = 44;
  localparam int HW  = MW / 2;
  localparam int PW  = 2 * MW;
  // squares and the cross term after the shift fit 48 bits
  localparam int SQ_W = 48;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [ZW-1:0]   ESC_MAG = ZW'(10) << FRAC_BITS;
  localparam logic [SQ_W:0]   ESC_SQ  = (SQ_W + 1)'(100) << FRAC_BITS;
  localparam logic [LIM_W-1:0] BAND_LOW_MAX = LIM_W'(15);

  localparam logic [CFG_W-1:0] X_ORIGIN_RST = CFG_W'(-64'sd1924145348608);
  localparam logic [CFG_W-1:0] X_STEP_RST   = CFG_W'(64'd3848290697);
  localparam logic [CFG_W-1:0] Y_ORIGIN_RST = CFG_W'(64'd1539316278886);
  localparam logic [CFG_W-1:0] Y_STEP_RST   = CFG_W'(-64'sd3848290697);
  localparam logic [LIM_W-1:0] LIMIT_RST    = LIM_W'(256);

  typedef enum logic [IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_X_STEP   = 3'd1,
    REG_Y_ORIGIN = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_ITER_LIM = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BAND_INSIDE = 2'd0,
    BAND_LOW    = 2'd1,
    BAND_HIGH   = 2'd2
  } band_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] column_out;
    logic [PIX_W-1:0] row_out;
    logic [LIM_W-1:0] iterations;
    logic             inside_res;
    logic [1:0]       band;
  } result_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] x_origin;
    logic signed [CFG_W-1:0] x_step;
    logic signed [CFG_W-1:0] y_origin;
    logic signed [CFG_W-1:0] y_step;
  } coord_cfg_t;

  // one mapped pixel handed from the front to the iteration engine
  typedef struct packed {
    logic [PIX_W-1:0]     px;
    logic [PIX_W-1:0]     py;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } point_t;

endpackage

// File: rtl/core/mbrot_front.sv
module mbrot_front import mbrot_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pixel_t     in_word_i,
  input  coord_cfg_t cfg_i,
  output logic       push_valid_o,
  output point_t     push_word_o,
  input  logic       push_ready_i
);

  // stage 1: pixel times step
  logic                 v1_q, v1_d;
  logic [PIX_W-1:0]     px1_q, py1_q;
  logic signed [CW-1:0] mx_q, my_q, mx_d, my_d;
  // stage 2: add origin
  logic                 v2_q, v2_d;
  point_t               pt_q, pt_d;

  logic s1_ready, s2_ready;

  assign s2_ready = !v2_q || push_ready_i;
  assign s1_ready = !v1_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign push_valid_o = v2_q;
  assign push_word_o  = pt_q;

  always_comb begin
    mx_d = CW'(cfg_i.x_step) * CW'($signed({1'b0, in_word_i.pixel_x}));
    my_d = CW'(cfg_i.y_step) * CW'($signed({1'b0, in_word_i.pixel_y}));
    v1_d = s1_ready ? in_valid_i : v1_q;
    v2_d = s2_ready ? v1_q : v2_q;
    pt_d.px = px1_q;
    pt_d.py = py1_q;
    pt_d.cx = CW'(cfg_i.x_origin) + mx_q;
    pt_d.cy = CW'(cfg_i.y_origin) + my_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      px1_q <= in_word_i.pixel_x;
      py1_q <= in_word_i.pixel_y;
      mx_q  <= mx_d;
      my_q  <= my_d;
    end
    if (s2_ready && v1_q) begin
      pt_q <= pt_d;
    end
  end

endmodule

// File: rtl/core/mbrot_queue.sv
module mbrot_queue import mbrot_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  point_t push_word_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output point_t pop_word_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  point_t           mem_q [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_word_o   = mem_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// File: rtl/core/mbrot_back.sv
module mbrot_back import mbrot_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  point_t           pop_word_i,
  input  logic [LIM_W-1:0] iteration_limit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_word_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [PIX_W-1:0]     px_q, px_d, py_q, py_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [ZW-1:0]        zx_q, zx_d, zy_q, zy_d;
  logic [LIM_W-1:0]     n_q, n_d, lim_q, lim_d;
  logic                 inside_q, inside_d;

  // 22x22 partial products of the split 44-bit magnitudes
  logic [2*HW-1:0] xx_hh_q, xx_hl_q, xx_ll_q;
  logic [2*HW-1:0] yy_hh_q, yy_hl_q, yy_ll_q;
  logic [2*HW-1:0] xy_hh_q, xy_hl_q, xy_lh_q, xy_ll_q;
  logic            pp_en;

  logic [SQ_W-1:0] sxx_q, sxx_d, syy_q, syy_d, pxy_q, pxy_d;

  logic          out_valid_q, out_valid_d;
  result_t       out_word_q, out_word_d;

  logic [ZW-1:0] ax_full, ay_full;
  logic [MW-1:0] ax, ay;
  logic [HW-1:0] axh, axl, ayh, ayl;
  logic          esc_mag;
  logic [PW-1:0] pr_xx, pr_yy, pr_xy;
  logic [SQ_W:0] mag_sq;
  logic          neg;

  assign pop_ready_o = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    ax_full = zx_q[ZW-1] ? (ZW'(0) - zx_q) : zx_q;
    ay_full = zy_q[ZW-1] ? (ZW'(0) - zy_q) : zy_q;
    esc_mag = (ax_full >= ESC_MAG) || (ay_full >= ESC_MAG);
    ax  = ax_full[MW-1:0];
    ay  = ay_full[MW-1:0];
    axh = ax[MW-1:HW];
    axl = ax[HW-1:0];
    ayh = ay[MW-1:HW];
    ayl = ay[HW-1:0];

    pr_xx = (PW'(xx_hh_q) << (2 * HW)) + (PW'(xx_hl_q) << (HW + 1)) + PW'(xx_ll_q);
    pr_yy = (PW'(yy_hh_q) << (2 * HW)) + (PW'(yy_hl_q) << (HW + 1)) + PW'(yy_ll_q);
    pr_xy = (PW'(xy_hh_q) << (2 * HW)) + (PW'(xy_hl_q) << HW)
          + (PW'(xy_lh_q) << HW) + PW'(xy_ll_q);
    // values are bounded, so the truncating shifts keep every bit
    sxx_d = pr_xx[FRAC_BITS +: SQ_W];
    syy_d = pr_yy[FRAC_BITS +: SQ_W];
    pxy_d = pr_xy[FRAC_BITS - 1 +: SQ_W];

    mag_sq = {1'b0, sxx_q} + {1'b0, syy_q};
    neg    = zx_q[ZW-1] ^ zy_q[ZW-1];
  end

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    zx_d        = zx_q;
    zy_d        = zy_q;
    n_d         = n_q;
    lim_d       = lim_q;
    inside_d    = inside_q;
    pp_en       = 1'b0;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          px_d    = pop_word_i.px;
          py_d    = pop_word_i.py;
          cx_d    = pop_word_i.cx;
          cy_d    = pop_word_i.cy;
          zx_d    = '0;
          zy_d    = '0;
          n_d     = '0;
          lim_d   = iteration_limit_i;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (n_q == lim_q) begin
          inside_d = 1'b1;
          state_d  = ST_DONE;
        end else if (esc_mag) begin
          inside_d = 1'b0;
          state_d  = ST_DONE;
        end else begin
          pp_en   = 1'b1;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (mag_sq >= ESC_SQ) begin
          inside_d = 1'b0;
          state_d  = ST_DONE;
        end else begin
          zx_d    = ZW'(sxx_q) - ZW'(syy_q) + ZW'(cx_q);
          zy_d    = neg ? (ZW'(cy_q) - ZW'(pxy_q)) : (ZW'(cy_q) + ZW'(pxy_q));
          n_d     = n_q + LIM_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_word_d.column_out = px_q;
          out_word_d.row_out    = py_q;
          out_word_d.iterations = n_q;
          out_word_d.inside_res = inside_q;
          if (inside_q) begin
            out_word_d.band = BAND_INSIDE;
          end else if (n_q <= BAND_LOW_MAX) begin
            out_word_d.band = BAND_LOW;
          end else begin
            out_word_d.band = BAND_HIGH;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    zx_q       <= zx_d;
    zy_q       <= zy_d;
    n_q        <= n_d;
    lim_q      <= lim_d;
    inside_q   <= inside_d;
    sxx_q      <= sxx_d;
    syy_q      <= syy_d;
    pxy_q      <= pxy_d;
    out_word_q <= out_word_d;
    if (pp_en) begin
      xx_hh_q <= axh * axh;
      xx_hl_q <= axh * axl;
      xx_ll_q <= axl * axl;
      yy_hh_q <= ayh * ayh;
      yy_hl_q <= ayh * ayl;
      yy_ll_q <= ayl * ayl;
      xy_hh_q <= axh * ayh;
      xy_hl_q <= axh * ayl;
      xy_lh_q <= axl * ayh;
      xy_ll_q <= axl * ayl;
    end
  end

endmodule

// File: rtl/core/mandelbrot_escape_time.sv
// Mandelbrot escape-time engine. Each word in is a pixel (column, row); it is
// mapped to c = origin + pixel * step in signed Q19.40 and z = z*z + c is run
// from zero until a component reaches 10.0, |z|^2 reaches 100.0 or the
// iteration limit is hit. Each pixel gives one result word: the pixel, the
// count, an inside flag and a color band. The mapping front runs as a
// two-stage pipeline into a two-word queue, so new pixels are taken while the
// iteration engine is busy and while a finished result waits on the output.
// Each iteration passes through the engine states ST_MUL (split 22x22 partial
// products), ST_SUM (their sum) and ST_UPD (the escape test and z update);
// a result waiting on the output stalls the engine. The engine handles one
// pixel at a time and sets the throughput. Configuration registers are
// written at any clock with cfg_we_i high and should only be changed while
// no pixel is in flight.
module mandelbrot_escape_time import mbrot_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pixel_t           in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_word_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CFG_W-1:0] x_origin_q, x_step_q, y_origin_q, y_step_q;
  logic [LIM_W-1:0] limit_q;
  coord_cfg_t       coord_cfg;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  point_t push_word, pop_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= X_ORIGIN_RST;
      x_step_q   <= X_STEP_RST;
      y_origin_q <= Y_ORIGIN_RST;
      y_step_q   <= Y_STEP_RST;
      limit_q    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_ORIGIN: x_origin_q <= cfg_data_i;
        REG_X_STEP:   x_step_q   <= cfg_data_i;
        REG_Y_ORIGIN: y_origin_q <= cfg_data_i;
        REG_Y_STEP:   y_step_q   <= cfg_data_i;
        REG_ITER_LIM: limit_q    <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign coord_cfg.x_origin = $signed(x_origin_q);
  assign coord_cfg.x_step   = $signed(x_step_q);
  assign coord_cfg.y_origin = $signed(y_origin_q);
  assign coord_cfg.y_step   = $signed(y_step_q);

  mbrot_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .cfg_i        (coord_cfg),
    .push_valid_o (push_valid),
    .push_word_o  (push_word),
    .push_ready_i (push_ready)
  );

  mbrot_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  mbrot_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_word_i        (pop_word),
    .iteration_limit_i (limit_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_word_o        (out_word_o)
  );

endmodule

// File: dv/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
  import mbrot_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_AT       = 320;
  localparam int HOLD_LEN      = 300;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 125;

  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MAG_ESC = 64'd10 << FRAC_BITS;
  localparam logic [63:0] SQ_ESC  = 64'd100 << FRAC_BITS;
  localparam logic [CFG_W-1:0] CFG_MIN = {1'b1, {(CFG_W-1){1'b0}}};
  localparam logic [CFG_W-1:0] CFG_MAX = {1'b0, {(CFG_W-1){1'b1}}};

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  pixel_t           in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  result_t          out_word;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  // shadow of the view registers
  logic signed [CFG_W-1:0] view_x_origin = X_ORIGIN_RST;
  logic signed [CFG_W-1:0] view_x_step   = X_STEP_RST;
  logic signed [CFG_W-1:0] view_y_origin = Y_ORIGIN_RST;
  logic signed [CFG_W-1:0] view_y_step   = Y_STEP_RST;
  logic [LIM_W-1:0]        view_limit    = LIMIT_RST;

  pixel_t  pixel_q[$];
  result_t pending_results[$];

  int       mismatch_cnt = 0;
  int       results_seen = 0;
  int       cycle_cnt    = 0;
  int       hold_left    = 0;
  logic     hold_done    = 1'b0;
  logic     in_taken     = 1'b0;
  logic     out_taken    = 1'b0;
  logic     in_calm      = 1'b0;
  logic     out_calm     = 1'b0;
  logic [2:0] in_gap     = '0;
  logic [2:0] out_stall  = '0;
  logic [2:0] rx_wait;
  result_t  want_r;

  mandelbrot_escape_time i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // exact product of two magnitudes, shifted down
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return 64'(full >> s);
  endfunction

  function automatic result_t escape_time(pixel_t p);
    longint      cx, cy, zx, zy;
    logic [63:0] ax, ay, sxx, syy, pxy;
    int          n;
    logic        in_set;
    result_t     r;
    cx = longint'(view_x_origin) + longint'(p.pixel_x) * longint'(view_x_step);
    cy = longint'(view_y_origin) + longint'(p.pixel_y) * longint'(view_y_step);
    zx = 0;
    zy = 0;
    n  = 0;
    while (n < int'(view_limit)) begin
      ax = (zx < 0) ? 64'(-zx) : 64'(zx);
      ay = (zy < 0) ? 64'(-zy) : 64'(zy);
      // a component at 10.0 or more escapes without squaring
      if (ax >= MAG_ESC || ay >= MAG_ESC) break;
      sxx = scaled_product(ax, ax, FRAC_BITS);
      syy = scaled_product(ay, ay, FRAC_BITS);
      if (sxx + syy >= SQ_ESC) break;
      // 2*|zx|*|zy| by one less bit of shift, sign applied after truncation
      pxy = scaled_product(ax, ay, FRAC_BITS - 1);
      zy  = ((zx < 0) != (zy < 0)) ? cy - longint'(pxy) : cy + longint'(pxy);
      zx  = longint'(sxx) - longint'(syy) + cx;
      n++;
    end
    in_set       = (n == int'(view_limit));
    r.column_out = p.pixel_x;
    r.row_out    = p.pixel_y;
    r.iterations = LIM_W'(n);
    r.inside_res = in_set;
    if (in_set) begin
      r.band = BAND_INSIDE;
    end else if (LIM_W'(n) <= BAND_LOW_MAX) begin
      r.band = BAND_LOW;
    end else begin
      r.band = BAND_HIGH;
    end
    return r;
  endfunction

  function automatic logic [2:0] pick_wait(logic calm);
    return calm ? 3'd0 : 3'($urandom_range(0, 5));
  endfunction

  function automatic logic [PIX_W-1:0] rand_coord();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return PIX_W'($urandom_range(0, 1023));
  endfunction

  // origin in units of 1/1024
  function automatic logic [CFG_W-1:0] random_origin(int lo, int hi);
    longint v;
    v = longint'(lo) + longint'($urandom_range(0, hi - lo));
    return CFG_W'(v <<< (FRAC_BITS - 10));
  endfunction

  function automatic logic [CFG_W-1:0] random_step(int max_shift);
    longint v;
    v = longint'($urandom_range(1, 1 << 23)) << $urandom_range(0, max_shift);
    if ($urandom_range(0, 1) == 1) v = -v;
    return CFG_W'(v);
  endfunction

  function automatic logic [CFG_W-1:0] random_word48();
    return CFG_W'({$urandom, $urandom});
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [LIM_W-1:0] got, logic [LIM_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0d, want %0d",
                                want_r.column_out, want_r.row_out, name, got, want));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_X_ORIGIN: view_x_origin = val;
      REG_X_STEP:   view_x_step   = val;
      REG_Y_ORIGIN: view_y_origin = val;
      REG_Y_STEP:   view_y_step   = val;
      REG_ITER_LIM: view_limit    = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_view(logic [CFG_W-1:0] xo, logic [CFG_W-1:0] xs,
                              logic [CFG_W-1:0] yo, logic [CFG_W-1:0] ys,
                              logic [LIM_W-1:0] lim);
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_ORIGIN, yo);
    write_reg(REG_Y_STEP, ys);
    write_reg(REG_ITER_LIM, CFG_W'(lim));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(int x, int y);
    pixel_q.push_back('{pixel_x: PIX_W'(x), pixel_y: PIX_W'(y)});
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      pixel_q.push_back('{pixel_x: rand_coord(), pixel_y: rand_coord()});
    end
  endtask

  // every pixel gives exactly one result, so an empty store means idle
  task automatic drain();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // pixel driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= '0;
    end else if (in_valid && !in_taken) begin
      // word still offered
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 3'd1;
    end else if (pixel_q.size() != 0) begin
      in_valid <= 1'b1;
      in_word  <= pixel_q.pop_front();
      in_gap   <= pick_wait(in_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= '0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 3'd1;
    end else if (out_taken) begin
      rx_wait = pick_wait(out_calm);
      out_ready <= (rx_wait == 0);
      out_stall <= (rx_wait == 0) ? 3'd0 : rx_wait - 3'd1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one long back-pressure stretch so the input side backs up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) pending_results.push_back(escape_time(in_word));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result for pixel (%0d,%0d) with no pixel pending",
                                    out_word.column_out, out_word.row_out));
        end else begin
          want_r = pending_results.pop_front();
          check_field("column", LIM_W'(out_word.column_out), LIM_W'(want_r.column_out));
          check_field("row", LIM_W'(out_word.row_out), LIM_W'(want_r.row_out));
          check_field("iterations", out_word.iterations, want_r.iterations);
          check_field("inside", LIM_W'(out_word.inside_res), LIM_W'(want_r.inside_res));
          check_field("band", LIM_W'(out_word.band), LIM_W'(want_r.band));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [LIM_W-1:0] lim;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset view: corners, alternating bits, a point in the main cardioid
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    send_pixel(500, 400);
    drain();

    // zero limit: no iteration at all, still inside
    program_view(X_ORIGIN_RST, X_STEP_RST, Y_ORIGIN_RST, Y_STEP_RST, '0);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    drain();

    // c = 3.0 escapes on the third test: inside at limit 2, escaped at 3
    program_view(CFG_W'(3 * ONE_Q), '0, '0, '0, LIM_W'(2));
    send_pixel(7, 9);
    drain();
    program_view(CFG_W'(3 * ONE_Q), '0, '0, '0, LIM_W'(3));
    send_pixel(7, 9);
    drain();

    // c = 0.26, slow escape past the cusp
    program_view(CFG_W'(64'd285873023222), '0, '0, '0, LIMIT_RST);
    send_pixel(33, 44);
    drain();

    // c = 0 never escapes: run the largest limits
    program_view('0, '0, '0, '0, LIM_W'(4096));
    send_pixel(1023, 0);
    drain();
    program_view('0, '0, '0, '0, '1);
    send_pixel(0, 1023);
    drain();

    // register extremes
    program_view(CFG_MIN, CFG_MAX, CFG_MAX, CFG_MIN, LIM_W'(5));
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    drain();
    program_view(CFG_MAX, CFG_MIN, CFG_MIN, CFG_MAX, LIM_W'(1));
    send_pixel(1023, 0);
    drain();

    // random pixels over the default view
    program_view(X_ORIGIN_RST, X_STEP_RST, Y_ORIGIN_RST, Y_STEP_RST, LIMIT_RST);
    queue_random(150);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        1: begin
          // arbitrary registers, mostly immediate escapes
          lim = LIM_W'($urandom_range(1, 16));
          program_view(random_word48(), random_word48(), random_word48(),
                       random_word48(), lim);
        end
        2: begin
          // zoomed in near the boundary, deeper limits
          lim = LIM_W'($urandom_range(32, 120));
          program_view(random_origin(-2048, 512), random_step(3),
                       random_origin(-1024, 1024), random_step(3), lim);
        end
        default: begin
          lim = LIM_W'($urandom_range(1, (ph % 4 == 0) ? 64 : 24));
          program_view(random_origin(-2560, 512), random_step(9),
                       random_origin(-1280, 1280), random_step(9), lim);
        end
      endcase
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      queue_random(PHASE_ITEMS);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
